### hdl/pcode_stack_machine_exec_top_defines.svh
// =============================================================================
// pcode_stack_machine_exec_top_defines.svh
// Assertion macros used by the checker of the P-code execution block.
// =============================================================================
`ifndef PCODE_STACK_MACHINE_EXEC_TOP_DEFINES_SVH
`define PCODE_STACK_MACHINE_EXEC_TOP_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define PSM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define PSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### hdl/psm_pkg.sv
// =============================================================================
// psm_pkg
// Types, constants and helpers for the P-code stack machine execution block.
// =============================================================================
`default_nettype none

package psm_pkg;

	localparam int STACK_DEPTH = 2048;
	localparam int SP_W        = $clog2(STACK_DEPTH);
	localparam int CODE_DEPTH  = 512;
	localparam int PC_W        = $clog2(CODE_DEPTH);
	localparam int MAX_LEVEL   = 3;
	localparam int LVL_W       = 2;
	localparam int WORD_W      = 32;
	localparam int ADDR_XW     = WORD_W + 2;
	localparam int Q_DEPTH     = 4;
	localparam int Q_AW        = $clog2(Q_DEPTH);
	localparam int IN_W        = 72;
	localparam int OUT_W       = 72;

	// Primary opcodes.
	localparam logic [3:0] OP_LIT = 4'd1;
	localparam logic [3:0] OP_OPR = 4'd2;
	localparam logic [3:0] OP_LOD = 4'd3;
	localparam logic [3:0] OP_STO = 4'd4;
	localparam logic [3:0] OP_CAL = 4'd5;
	localparam logic [3:0] OP_INC = 4'd6;
	localparam logic [3:0] OP_JMP = 4'd7;
	localparam logic [3:0] OP_JPC = 4'd8;
	localparam logic [3:0] OP_SIO = 4'd9;

	// Sub-operations carried in the modifier.
	localparam logic [WORD_W-1:0] OPR_RET = 32'd0;
	localparam logic [WORD_W-1:0] OPR_NEG = 32'd1;
	localparam logic [WORD_W-1:0] OPR_ADD = 32'd2;
	localparam logic [WORD_W-1:0] OPR_SUB = 32'd3;
	localparam logic [WORD_W-1:0] OPR_MUL = 32'd4;
	localparam logic [WORD_W-1:0] OPR_DIV = 32'd5;
	localparam logic [WORD_W-1:0] OPR_ODD = 32'd6;
	localparam logic [WORD_W-1:0] OPR_MOD = 32'd7;
	localparam logic [WORD_W-1:0] OPR_EQL = 32'd8;
	localparam logic [WORD_W-1:0] OPR_NEQ = 32'd9;
	localparam logic [WORD_W-1:0] OPR_LSS = 32'd10;
	localparam logic [WORD_W-1:0] OPR_LEQ = 32'd11;
	localparam logic [WORD_W-1:0] OPR_GTR = 32'd12;
	localparam logic [WORD_W-1:0] OPR_GEQ = 32'd13;
	localparam logic [WORD_W-1:0] SIO_WRITE = 32'd1;
	localparam logic [WORD_W-1:0] SIO_READ  = 32'd2;
	localparam logic [WORD_W-1:0] SIO_HALT  = 32'd3;

	// Error codes.
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_DIV0  = 2'd1;
	localparam logic [1:0] ERR_RANGE = 2'd2;

	typedef enum logic [3:0] {
		K_NOP, K_LIT, K_RET, K_NEG, K_ODD, K_ALU, K_LOD, K_STO,
		K_CAL, K_INC, K_JMP, K_JPC, K_WRITE, K_READ, K_HALT
	} kind_t;

	typedef enum logic [3:0] {
		ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_MOD,
		ALU_EQL, ALU_NEQ, ALU_LSS, ALU_LEQ, ALU_GTR, ALU_GEQ
	} alu_t;

	typedef struct packed {
		kind_t              kind;
		alu_t               alu;
		logic [LVL_W-1:0]   level;
		logic [WORD_W-1:0]  modifier;
		logic [WORD_W-1:0]  read_value;
	} instr_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_WALK, ST_WALKW, ST_RD1, ST_RD2,
		ST_EXEC, ST_DIV, ST_WB, ST_FIN
	} state_t;

	function automatic logic in_stack(input logic signed [ADDR_XW-1:0] a);
		return (a >= 0) && (a < $signed(ADDR_XW'(STACK_DEPTH)));
	endfunction

	function automatic logic signed [ADDR_XW-1:0] sext_word(input logic [WORD_W-1:0] v);
		return $signed({{(ADDR_XW-WORD_W){v[WORD_W-1]}}, v});
	endfunction

endpackage

`default_nettype wire

### hdl/psm_front.sv
// =============================================================================
// psm_front
// Accepts instruction items and sorts them into execution kinds.
// =============================================================================
`default_nettype none

module psm_front
	import psm_pkg::*;
(
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [IN_W-1:0]  s_axis_tdata,
	input  wire logic             q_full,
	input  wire logic             clearing,
	output logic                  q_push,
	output instr_t                q_data
);

	logic [3:0]        opcode;
	logic [LVL_W-1:0]  level;
	logic [WORD_W-1:0] modifier;

	assign opcode   = s_axis_tdata[3:0];
	assign level    = s_axis_tdata[5:4];
	assign modifier = s_axis_tdata[37:6];

	assign s_axis_tready = !q_full && !clearing;
	assign q_push        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		q_data.kind       = K_NOP;
		q_data.alu        = ALU_ADD;
		q_data.level      = (level > LVL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : level;
		q_data.modifier   = modifier;
		q_data.read_value = s_axis_tdata[69:38];
		unique case (opcode)
			OP_LIT: q_data.kind = K_LIT;
			OP_OPR: begin
				q_data.kind = K_ALU;
				unique case (modifier)
					OPR_RET: q_data.kind = K_RET;
					OPR_NEG: q_data.kind = K_NEG;
					OPR_ODD: q_data.kind = K_ODD;
					OPR_ADD: q_data.alu = ALU_ADD;
					OPR_SUB: q_data.alu = ALU_SUB;
					OPR_MUL: q_data.alu = ALU_MUL;
					OPR_DIV: q_data.alu = ALU_DIV;
					OPR_MOD: q_data.alu = ALU_MOD;
					OPR_EQL: q_data.alu = ALU_EQL;
					OPR_NEQ: q_data.alu = ALU_NEQ;
					OPR_LSS: q_data.alu = ALU_LSS;
					OPR_LEQ: q_data.alu = ALU_LEQ;
					OPR_GTR: q_data.alu = ALU_GTR;
					OPR_GEQ: q_data.alu = ALU_GEQ;
					default: q_data.kind = K_NOP;
				endcase
			end
			OP_LOD: q_data.kind = K_LOD;
			OP_STO: q_data.kind = K_STO;
			OP_CAL: q_data.kind = K_CAL;
			OP_INC: q_data.kind = K_INC;
			OP_JMP: q_data.kind = K_JMP;
			OP_JPC: q_data.kind = K_JPC;
			OP_SIO: begin
				unique case (modifier)
					SIO_WRITE: q_data.kind = K_WRITE;
					SIO_READ:  q_data.kind = K_READ;
					SIO_HALT:  q_data.kind = K_HALT;
					default:   q_data.kind = K_NOP;
				endcase
			end
			default: q_data.kind = K_NOP;
		endcase
	end

endmodule

`default_nettype wire

### hdl/psm_queue.sv
// =============================================================================
// psm_queue
// Short instruction queue between the front end and the executor.
// =============================================================================
`default_nettype none

module psm_queue
	import psm_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  instr_t      push_data,
	input  wire logic   pop,
	output logic        full,
	output logic        not_empty,
	output instr_t      head
);

	instr_t            entry_q [Q_DEPTH];
	logic [Q_AW-1:0]   wptr_q;
	logic [Q_AW-1:0]   rptr_q;
	logic [Q_AW:0]     count_q;

	assign full      = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + Q_AW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + Q_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (Q_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (Q_AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

### hdl/psm_div.sv
// =============================================================================
// psm_div
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// =============================================================================
`default_nettype none

module psm_div
	import psm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [WORD_W-1:0]  dividend,
	input  wire logic [WORD_W-1:0]  divisor,
	output logic                    done,
	output logic [WORD_W-1:0]       quotient,
	output logic [WORD_W-1:0]       remainder
);

	localparam int CNT_W = $clog2(WORD_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W:0]   rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] dvs_q;
	logic              negq_q;
	logic              negr_q;
	logic [WORD_W:0]   shifted;
	logic [WORD_W:0]   trial;

	assign shifted = {rem_q[WORD_W-1:0], quo_q[WORD_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(WORD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Works on magnitudes; the most negative dividend fits as an unsigned magnitude.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend[WORD_W-1] ? (~dividend + WORD_W'(1)) : dividend;
			dvs_q  <= divisor[WORD_W-1] ? (~divisor + WORD_W'(1)) : divisor;
			negq_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
			negr_q <= dividend[WORD_W-1];
		end else if (busy_q) begin
			if (!trial[WORD_W]) begin
				rem_q <= trial;
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = negq_q ? (~quo_q + WORD_W'(1)) : quo_q;
	assign remainder = negr_q ? (~rem_q[WORD_W-1:0] + WORD_W'(1)) : rem_q[WORD_W-1:0];

endmodule

`default_nettype wire

### hdl/psm_back.sv
// =============================================================================
// psm_back
// Executor: static link walk, stack reads, ALU, write-back and result register.
// =============================================================================
`default_nettype none

module psm_back
	import psm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	input  instr_t                 q_head,
	output logic                   q_pop,
	output logic                   clearing,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [OUT_W-1:0]       m_axis_tdata
);

	state_t state_q, state_nxt;

	logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
	logic [WORD_W-1:0] rdata_q;
	logic              mem_we;
	logic [SP_W-1:0]   mem_wa;
	logic [WORD_W-1:0] mem_wd;
	logic [SP_W-1:0]   mem_ra;

	logic [SP_W-1:0]   sp_q, bp_q, clr_q, waddr_q, nsp_q, nbp_q;
	logic [PC_W-1:0]   pc_q, npc_q;
	instr_t            ins_q;
	logic [WORD_W-1:0] x_q, a_q, res_q, oval_q;
	logic [LVL_W-1:0]  lvl_q;
	logic              walk_err_q, dowr_q, ov_q, halt_q;
	logic [1:0]        wcnt_q, err_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	logic [PC_W-1:0]            pc1;
	logic signed [ADDR_XW-1:0]  spx, bpx, bx, msx, lod_addr;
	logic                       need_walk, walk_ok, out_free, div_start, div_done;
	logic [WORD_W-1:0]          div_q, div_r;
	logic signed [WORD_W-1:0]   x, y;
	logic [WORD_W-1:0]          alu_res;

	logic                       e_err2, e_err1, e_wr, e_ov, e_halt;
	logic [1:0]                 e_err;
	logic signed [ADDR_XW-1:0]  e_nsp, e_nbp;
	logic [PC_W-1:0]            e_npc;
	logic [WORD_W-1:0]          e_res;
	logic [SP_W-1:0]            e_wa;

	assign pc1      = pc_q + PC_W'(1);
	assign spx      = $signed({{(ADDR_XW-SP_W){1'b0}}, sp_q});
	assign bpx      = $signed({{(ADDR_XW-SP_W){1'b0}}, bp_q});
	assign bx       = sext_word(x_q);
	assign msx      = sext_word(ins_q.modifier);
	assign lod_addr = bx + msx;
	assign x        = $signed(a_q);
	assign y        = $signed(rdata_q);
	assign out_free = !out_valid_q || m_axis_tready;
	assign need_walk = (ins_q.kind == K_LOD || ins_q.kind == K_STO || ins_q.kind == K_CAL)
		&& (lvl_q != '0);
	assign walk_ok  = in_stack(bx + ADDR_XW'(1));
	assign clearing = (state_q == ST_CLEAR);

	// Stack memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_wa] <= mem_wd;
		end
		rdata_q <= stack_mem[mem_ra];
	end

	psm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (a_q),
		.divisor   (rdata_q),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_r)
	);

	always_comb begin
		unique case (ins_q.alu)
			ALU_ADD: alu_res = a_q + rdata_q;
			ALU_SUB: alu_res = a_q - rdata_q;
			ALU_MUL: alu_res = a_q * rdata_q;
			ALU_EQL: alu_res = {{(WORD_W-1){1'b0}}, x == y};
			ALU_NEQ: alu_res = {{(WORD_W-1){1'b0}}, x != y};
			ALU_LSS: alu_res = {{(WORD_W-1){1'b0}}, x < y};
			ALU_LEQ: alu_res = {{(WORD_W-1){1'b0}}, x <= y};
			ALU_GTR: alu_res = {{(WORD_W-1){1'b0}}, x > y};
			ALU_GEQ: alu_res = {{(WORD_W-1){1'b0}}, x >= y};
			default: alu_res = '0;
		endcase
	end

	// Outcome of the instruction, evaluated in the execute state.
	always_comb begin
		e_err2 = 1'b0;
		e_nsp  = spx;
		e_nbp  = bpx;
		e_npc  = pc1;
		e_res  = '0;
		e_wa   = sp_q;
		e_wr   = 1'b0;
		e_ov   = 1'b0;
		e_halt = 1'b0;
		unique case (ins_q.kind)
			K_LIT: begin
				e_nsp  = spx + ADDR_XW'(1);
				e_err2 = !in_stack(e_nsp);
				e_res  = ins_q.modifier;
				e_wa   = sp_q + SP_W'(1);
				e_wr   = 1'b1;
			end
			K_RET: begin
				e_nsp  = bpx - ADDR_XW'(1);
				e_nbp  = sext_word(rdata_q);
				e_npc  = a_q[PC_W-1:0];
				e_err2 = !in_stack(e_nsp) || !in_stack(bpx + ADDR_XW'(3)) || !in_stack(e_nbp);
			end
			K_NEG: begin
				e_res = WORD_W'(0) - a_q;
				e_wr  = 1'b1;
			end
			K_ODD: begin
				e_res = {{(WORD_W-1){1'b0}}, a_q[0]};
				e_wr  = 1'b1;
			end
			K_ALU: begin
				e_nsp  = spx - ADDR_XW'(1);
				e_err2 = !in_stack(e_nsp);
				e_res  = alu_res;
				e_wa   = sp_q - SP_W'(1);
				e_wr   = 1'b1;
			end
			K_LOD: begin
				e_nsp  = spx + ADDR_XW'(1);
				e_err2 = walk_err_q || !in_stack(lod_addr) || !in_stack(e_nsp);
				e_res  = a_q;
				e_wa   = sp_q + SP_W'(1);
				e_wr   = 1'b1;
			end
			K_STO: begin
				e_nsp  = spx - ADDR_XW'(1);
				e_err2 = walk_err_q || !in_stack(lod_addr) || !in_stack(e_nsp);
				e_res  = a_q;
				e_wa   = lod_addr[SP_W-1:0];
				e_wr   = 1'b1;
			end
			K_CAL: begin
				e_err2 = walk_err_q || !in_stack(spx + ADDR_XW'(4));
				e_nbp  = spx + ADDR_XW'(1);
				e_npc  = ins_q.modifier[PC_W-1:0];
				e_wa   = sp_q + SP_W'(1);
				e_wr   = 1'b1;
			end
			K_INC: begin
				e_nsp  = spx + msx;
				e_err2 = !in_stack(e_nsp);
			end
			K_JMP: e_npc = ins_q.modifier[PC_W-1:0];
			K_JPC: begin
				e_nsp  = spx - ADDR_XW'(1);
				e_err2 = !in_stack(e_nsp);
				if (a_q == '0) begin
					e_npc = ins_q.modifier[PC_W-1:0];
				end
			end
			K_WRITE: begin
				e_nsp  = spx - ADDR_XW'(1);
				e_err2 = !in_stack(e_nsp);
				e_ov   = 1'b1;
			end
			K_READ: begin
				e_nsp  = spx + ADDR_XW'(1);
				e_err2 = !in_stack(e_nsp);
				e_res  = ins_q.read_value;
				e_wa   = sp_q + SP_W'(1);
				e_wr   = 1'b1;
			end
			K_HALT: begin
				e_nsp  = '0;
				e_nbp  = '0;
				e_npc  = '0;
				e_halt = 1'b1;
			end
			default: ;
		endcase
	end

	assign e_err1 = (ins_q.kind == K_ALU) && (ins_q.alu == ALU_DIV || ins_q.alu == ALU_MOD)
		&& (rdata_q == '0) && !e_err2;
	assign e_err  = e_err2 ? ERR_RANGE : (e_err1 ? ERR_DIV0 : ERR_NONE);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == SP_W'(STACK_DEPTH - 1)) state_nxt = ST_IDLE;
			ST_IDLE:  if (q_valid) state_nxt = ST_WALK;
			ST_WALK:  state_nxt = (need_walk && walk_ok) ? ST_WALKW : ST_RD1;
			ST_WALKW: state_nxt = ST_WALK;
			ST_RD1:   state_nxt = ST_RD2;
			ST_RD2:   state_nxt = ST_EXEC;
			ST_EXEC:  state_nxt = div_start ? ST_DIV : ST_WB;
			ST_DIV:   if (div_done) state_nxt = ST_WB;
			ST_WB: begin
				if (!(ins_q.kind == K_CAL && dowr_q && wcnt_q != 2'd3)) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN:   if (out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// Memory and handshake controls.
	always_comb begin
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_wa    = waddr_q;
		mem_wd    = res_q;
		mem_ra    = sp_q;
		div_start = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
			end
			ST_IDLE:  q_pop = q_valid;
			ST_WALK:  mem_ra = x_q[SP_W-1:0] + SP_W'(1);
			ST_RD1: begin
				priority if (ins_q.kind == K_RET) begin
					mem_ra = bp_q + SP_W'(3);
				end else if (ins_q.kind == K_ALU) begin
					mem_ra = sp_q - SP_W'(1);
				end else if (ins_q.kind == K_LOD) begin
					mem_ra = lod_addr[SP_W-1:0];
				end else begin
					mem_ra = sp_q;
				end
			end
			ST_RD2:   mem_ra = (ins_q.kind == K_RET) ? (bp_q + SP_W'(2)) : sp_q;
			ST_EXEC: begin
				div_start = (ins_q.kind == K_ALU)
					&& (ins_q.alu == ALU_DIV || ins_q.alu == ALU_MOD)
					&& (e_err == ERR_NONE);
			end
			ST_WB: begin
				mem_we = dowr_q;
				if (ins_q.kind == K_CAL) begin
					mem_wa = waddr_q + SP_W'(wcnt_q);
					unique case (wcnt_q)
						2'd0:    mem_wd = '0;
						2'd1:    mem_wd = x_q;
						2'd2:    mem_wd = {{(WORD_W-SP_W){1'b0}}, bp_q};
						default: mem_wd = {{(WORD_W-PC_W){1'b0}}, pc1};
					endcase
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			sp_q        <= '0;
			bp_q        <= SP_W'(1);
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + SP_W'(1);
			end
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
				sp_q        <= nsp_q;
				bp_q        <= nbp_q;
				pc_q        <= npc_q;
			end
		end
	end

	// Working registers of the current instruction.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ins_q      <= q_head;
				lvl_q      <= q_head.level;
				x_q        <= {{(WORD_W-SP_W){1'b0}}, bp_q};
				walk_err_q <= 1'b0;
				wcnt_q     <= '0;
			end
			ST_WALK: begin
				if (need_walk && !walk_ok) begin
					walk_err_q <= 1'b1;
					lvl_q      <= '0;
				end
			end
			ST_WALKW: begin
				x_q   <= rdata_q;
				lvl_q <= lvl_q - LVL_W'(1);
			end
			ST_RD2: a_q <= rdata_q;
			ST_EXEC: begin
				res_q   <= e_res;
				waddr_q <= e_wa;
				err_q   <= e_err;
				if (e_err != ERR_NONE) begin
					nsp_q  <= sp_q;
					nbp_q  <= bp_q;
					npc_q  <= pc1;
					dowr_q <= 1'b0;
					ov_q   <= 1'b0;
					oval_q <= '0;
					halt_q <= 1'b0;
				end else begin
					nsp_q  <= e_nsp[SP_W-1:0];
					nbp_q  <= e_nbp[SP_W-1:0];
					npc_q  <= e_npc;
					dowr_q <= e_wr;
					ov_q   <= e_ov;
					oval_q <= e_ov ? a_q : '0;
					halt_q <= e_halt;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					res_q <= (ins_q.alu == ALU_DIV) ? div_q : div_r;
				end
			end
			ST_WB: wcnt_q <= wcnt_q + 2'd1;
			ST_FIN: begin
				if (out_free) begin
					out_data_q <= {5'd0, err_q, halt_q, oval_q, ov_q, nsp_q, nbp_q, npc_q};
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

### hdl/pcode_stack_machine_exec_top.sv
// =============================================================================
// pcode_stack_machine_exec_top
// P-code stack machine: runs one instruction per input item, one result item each.
// =============================================================================
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   opcode[3:0] level[5:4] modifier[37:6] read_value[69:38]
// m_axis    out  next_pc[8:0] base_ptr[19:9] stack_ptr[30:20] out_valid[31]
//                out_value[63:32] halted[64] error[66:65]
//
// An instruction spends longer in the executor for each static link walked,
// for a call and for divide or modulo; the single stack memory port and the
// bit-serial divider set this.
// After reset the executor clears the 2048-word stack, one word per cycle, and
// s_axis_tready stays low until the clear is done.
// A four-entry queue keeps accepting items, until it is full, while a result waits on m_axis.
`default_nettype none

module pcode_stack_machine_exec_top
	import psm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [IN_W-1:0]   s_axis_tdata,  // opcode, level, modifier, read_value
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [OUT_W-1:0]       m_axis_tdata   // next_pc, base_ptr, stack_ptr,
	                                              // out_valid, out_value, halted, error
);

	logic   q_full, q_push, q_pop, q_valid, clearing;
	instr_t q_in, q_head;

	psm_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_full        (q_full),
		.clearing      (clearing),
		.q_push        (q_push),
		.q_data        (q_in)
	);

	psm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (q_head)
	);

	psm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.clearing      (clearing),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

`default_nettype wire

### hdl/psm_checker.sv
// =============================================================================
// psm_checker
// Port-level checks on the result stream of the P-code execution block.
// =============================================================================
`default_nettype none

`include "pcode_stack_machine_exec_top_defines.svh"

module psm_checker
	import psm_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              m_axis_tvalid,
	input wire logic              m_axis_tready,
	input wire logic [OUT_W-1:0]  m_axis_tdata
);

	logic [1:0] err;
	assign err = m_axis_tdata[66:65];

	`PSM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result item changed while stalled")
	`PSM_ASSERT_SAME(a_err_code, m_axis_tvalid, err == ERR_NONE || err == ERR_DIV0 || err == ERR_RANGE, "undefined error code")
	`PSM_ASSERT_SAME(a_halt_regs, m_axis_tvalid && m_axis_tdata[64], m_axis_tdata[30:0] == 31'd0 && err == ERR_NONE, "halt result with live registers")
	`PSM_ASSERT_SAME(a_err_quiet, m_axis_tvalid && err != ERR_NONE, m_axis_tdata[64:31] == 34'd0, "faulting item produced output or halt")

endmodule

bind pcode_stack_machine_exec_top psm_checker u_psm_checker (.*);

`default_nettype wire

### tb/pcode_stack_machine_exec_top_tb.sv
// -----------------------------------------------------------------------------
// pcode_stack_machine_exec_top_tb
// Runs P-code instructions through the stream ports and predicts every result
// with a behavioral copy of the stack machine. It checks each result field by
// field, under several patterns of sender gaps and receiver stalls.
// -----------------------------------------------------------------------------
`default_nettype none

module pcode_stack_machine_exec_top_tb;
	import psm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES = 7;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 80;
	localparam int RANDOM_ITEMS = 900;

	typedef struct {
		logic [PC_W-1:0]   pc;
		logic [SP_W-1:0]   bp;
		logic [SP_W-1:0]   sp;
		logic              ov;
		logic [WORD_W-1:0] oval;
		logic              halt;
		logic [1:0]        err;
	} exec_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	// Predicted machine state.
	logic [WORD_W-1:0] mem_words [STACK_DEPTH];
	logic [PC_W-1:0] cur_pc;
	longint cur_bp, cur_sp;

	logic [IN_W-1:0] instr_pending[$];
	exec_result_t result_expected[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;
	int results_seen = 0;
	int errors_seen = 0;
	int writes_seen = 0;
	int failures = 0;
	longint cycle_count = 0;

	pcode_stack_machine_exec_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #1 clk = ~clk;

	function automatic bit fits(longint a);
		return a >= 0 && a < STACK_DEPTH;
	endfunction

	function automatic longint sx(logic [WORD_W-1:0] v);
		return longint'($signed(v));
	endfunction

	function automatic logic [WORD_W-1:0] peek(longint a);
		return fits(a) ? mem_words[a] : '0;
	endfunction

	// Executes one instruction against the predicted state and returns its result.
	task automatic execute_pcode(input logic [3:0] op, input logic [1:0] lvl,
		input logic [WORD_W-1:0] um, input logic [WORD_W-1:0] rv, output exec_result_t res);
		longint nsp, nbp, b, addr, x, y, r;
		logic [PC_W-1:0] pc1, npc;
		longint wa[4];
		logic [WORD_W-1:0] wv[4];
		int nw;
		bit ok;
		logic [1:0] err;
		logic ov, halt;
		logic [WORD_W-1:0] oval;
		logic [WORD_W-1:0] t;
		nsp = cur_sp; nbp = cur_bp; b = 0; r = 0; nw = 0; ok = 1;
		err = ERR_NONE; ov = 0; halt = 0; oval = '0;
		pc1 = cur_pc + 1'b1;
		npc = pc1;
		// Static link walk, used by lod, sto and cal.
		if (op == OP_LOD || op == OP_STO || op == OP_CAL) begin
			b = cur_bp;
			for (int i = 0; i < lvl; i++) begin
				if (!fits(b + 1)) begin
					ok = 0;
					break;
				end
				b = sx(mem_words[b + 1]);
			end
		end
		case (op)
			OP_LIT: begin
				nsp = cur_sp + 1;
				if (!fits(nsp)) err = ERR_RANGE;
				else begin wa[nw] = nsp; wv[nw] = um; nw++; end
			end
			OP_OPR: begin
				if (um == OPR_RET) begin
					nsp = cur_bp - 1;
					if (!fits(nsp) || !fits(cur_bp + 3)) err = ERR_RANGE;
					else begin
						t = peek(cur_bp + 3);
						npc = t[PC_W-1:0];
						nbp = sx(peek(cur_bp + 2));
						if (!fits(nbp)) err = ERR_RANGE;
					end
				end else if (um == OPR_NEG) begin
					wa[nw] = cur_sp; wv[nw] = -peek(cur_sp); nw++;
				end else if (um == OPR_ODD) begin
					t = peek(cur_sp);
					wa[nw] = cur_sp; wv[nw] = {31'b0, t[0]}; nw++;
				end else if (um >= OPR_ADD && um <= OPR_GEQ) begin
					nsp = cur_sp - 1;
					if (!fits(nsp)) err = ERR_RANGE;
					else begin
						x = sx(peek(nsp));
						y = sx(peek(cur_sp));
						case (um)
							OPR_ADD: r = x + y;
							OPR_SUB: r = x - y;
							OPR_MUL: r = x * y;
							OPR_DIV: if (y == 0) err = ERR_DIV0; else r = x / y;
							OPR_MOD: if (y == 0) err = ERR_DIV0; else r = x % y;
							OPR_EQL: r = x == y;
							OPR_NEQ: r = x != y;
							OPR_LSS: r = x < y;
							OPR_LEQ: r = x <= y;
							OPR_GTR: r = x > y;
							default: r = x >= y;
						endcase
						wa[nw] = nsp; wv[nw] = r[31:0]; nw++;
					end
				end
			end
			OP_LOD, OP_STO: begin
				nsp = (op == OP_LOD) ? cur_sp + 1 : cur_sp - 1;
				addr = b + sx(um);
				if (!ok || !fits(addr) || !fits(nsp)) err = ERR_RANGE;
				else if (op == OP_LOD) begin
					wa[nw] = nsp; wv[nw] = peek(addr); nw++;
				end else begin
					wa[nw] = addr; wv[nw] = peek(cur_sp); nw++;
				end
			end
			OP_CAL: begin
				if (!ok || !fits(cur_sp + 4)) err = ERR_RANGE;
				else begin
					wa[0] = cur_sp + 1; wv[0] = '0;
					wa[1] = cur_sp + 2; wv[1] = b[31:0];
					wa[2] = cur_sp + 3; wv[2] = cur_bp[31:0];
					wa[3] = cur_sp + 4; wv[3] = {23'b0, pc1};
					nw = 4;
					nbp = cur_sp + 1;
					npc = um[PC_W-1:0];
				end
			end
			OP_INC: begin
				nsp = cur_sp + sx(um);
				if (!fits(nsp)) err = ERR_RANGE;
			end
			OP_JMP: npc = um[PC_W-1:0];
			OP_JPC: begin
				nsp = cur_sp - 1;
				if (!fits(nsp)) err = ERR_RANGE;
				else if (peek(cur_sp) == '0) npc = um[PC_W-1:0];
			end
			OP_SIO: begin
				if (um == SIO_WRITE) begin
					nsp = cur_sp - 1;
					if (!fits(nsp)) err = ERR_RANGE;
					else begin ov = 1; oval = peek(cur_sp); end
				end else if (um == SIO_READ) begin
					nsp = cur_sp + 1;
					if (!fits(nsp)) err = ERR_RANGE;
					else begin wa[nw] = nsp; wv[nw] = rv; nw++; end
				end else if (um == SIO_HALT) begin
					nsp = 0; nbp = 0; npc = '0; halt = 1;
				end
			end
			default: ;
		endcase
		// A faulting instruction only advances the program counter.
		if (err != ERR_NONE) begin
			nsp = cur_sp; nbp = cur_bp; npc = pc1;
			nw = 0; ov = 0; oval = '0; halt = 0;
		end
		for (int i = 0; i < nw; i++)
			if (fits(wa[i])) mem_words[wa[i]] = wv[i];
		cur_sp = nsp; cur_bp = nbp; cur_pc = npc;
		res.pc = npc; res.bp = nbp[SP_W-1:0]; res.sp = nsp[SP_W-1:0];
		res.ov = ov; res.oval = oval; res.halt = halt; res.err = err;
	endtask

	task automatic issue_instr(input logic [3:0] op, input logic [1:0] lvl,
		input logic [WORD_W-1:0] um, input logic [WORD_W-1:0] rv);
		exec_result_t res;
		execute_pcode(op, lvl, um, rv, res);
		instr_pending.push_back({2'b0, rv, um, lvl, op});
		result_expected.push_back(res);
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return $urandom_range(0, 20);
			default: return $urandom;
		endcase
	endfunction

	// Mostly well-formed instructions with small offsets, plus some noise.
	task automatic random_instr();
		int pick;
		logic [1:0] lvl;
		logic [WORD_W-1:0] um;
		pick = $urandom_range(0, 99);
		lvl = 2'($urandom_range(0, 3));
		if (pick < 18) issue_instr(OP_LIT, lvl, pick_word(), $urandom);
		else if (pick < 38) begin
			um = ($urandom_range(0, 19) == 0) ? pick_word() : $urandom_range(0, 13);
			issue_instr(OP_OPR, lvl, um, $urandom);
		end else if (pick < 58) begin
			um = ($urandom_range(0, 9) == 0) ? pick_word() : $urandom_range(0, 6);
			issue_instr(pick < 48 ? OP_LOD : OP_STO, lvl, um, $urandom);
		end else if (pick < 63) issue_instr(OP_CAL, lvl, $urandom, $urandom);
		else if (pick < 70) begin
			if ($urandom_range(0, 19) == 0) um = pick_word();
			else if (cur_sp > 300) um = -$urandom_range(0, 60);
			else um = $urandom_range(0, 8);
			issue_instr(OP_INC, lvl, um, $urandom);
		end else if (pick < 74) issue_instr(OP_JMP, lvl, $urandom, $urandom);
		else if (pick < 80) issue_instr(OP_JPC, lvl, $urandom, $urandom);
		else if (pick < 92) begin
			um = ($urandom_range(0, 24) == 0) ? SIO_HALT : $urandom_range(1, 2);
			if ($urandom_range(0, 29) == 0) um = pick_word();
			issue_instr(OP_SIO, lvl, um, $urandom);
		end else
			issue_instr(4'($urandom_range(0, 15)), lvl, $urandom, $urandom);
	endtask

	task automatic wait_idle();
		while (instr_pending.size() != 0 || result_expected.size() != 0 || s_axis_tvalid)
			@(posedge clk);
	endtask

	// Sender.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) items_sent <= items_sent + 1;
			if (!s_axis_tvalid || s_axis_tready) begin
				if (instr_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_axis_tdata <= instr_pending.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver and checker.
	always @(posedge clk or negedge arst_n) begin
		exec_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen <= results_seen + 1;
				if (result_expected.size() == 0) begin
					$error("result item with no instruction outstanding: %h", m_axis_tdata);
					failures = failures + 1;
				end else begin
					want = result_expected.pop_front();
					if (want.err != ERR_NONE) errors_seen <= errors_seen + 1;
					if (want.ov) writes_seen <= writes_seen + 1;
					if (m_axis_tdata[8:0] !== want.pc) begin
						$error("next_pc: expected %0d, got %0d", want.pc, m_axis_tdata[8:0]);
						failures = failures + 1;
					end
					if (m_axis_tdata[19:9] !== want.bp) begin
						$error("base_ptr: expected %0d, got %0d", want.bp, m_axis_tdata[19:9]);
						failures = failures + 1;
					end
					if (m_axis_tdata[30:20] !== want.sp) begin
						$error("stack_ptr: expected %0d, got %0d", want.sp, m_axis_tdata[30:20]);
						failures = failures + 1;
					end
					if (m_axis_tdata[31] !== want.ov) begin
						$error("out_valid: expected %0d, got %0d", want.ov, m_axis_tdata[31]);
						failures = failures + 1;
					end
					if (m_axis_tdata[63:32] !== want.oval) begin
						$error("out_value: expected %h, got %h", want.oval, m_axis_tdata[63:32]);
						failures = failures + 1;
					end
					if (m_axis_tdata[64] !== want.halt) begin
						$error("halted: expected %0d, got %0d", want.halt, m_axis_tdata[64]);
						failures = failures + 1;
					end
					if (m_axis_tdata[66:65] !== want.err) begin
						$error("error: expected %0d, got %0d", want.err, m_axis_tdata[66:65]);
						failures = failures + 1;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, result_expected.size());
			$display("pcode_stack_machine_exec_top_tb: FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < STACK_DEPTH; i++) mem_words[i] = '0;
		cur_pc = '0; cur_bp = 1; cur_sp = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: arithmetic corners, faults, call/return and I/O.
		issue_instr(OP_OPR, 2'd0, OPR_ADD, '0);            // underflow at sp 0
		issue_instr(OP_LIT, 2'd0, 32'h8000_0000, '0);
		issue_instr(OP_LIT, 2'd0, 32'hffff_ffff, '0);
		issue_instr(OP_OPR, 2'd0, OPR_DIV, '0);            // most negative over -1
		issue_instr(OP_LIT, 2'd0, 32'h7fff_ffff, '0);
		issue_instr(OP_LIT, 2'd0, 32'd0, '0);
		issue_instr(OP_OPR, 2'd0, OPR_MOD, '0);            // modulo by zero
		issue_instr(OP_OPR, 2'd0, OPR_DIV, '0);            // divide by zero
		issue_instr(OP_SIO, 2'd0, SIO_READ, 32'hffff_fffd);
		issue_instr(OP_OPR, 2'd0, OPR_ODD, '0);            // odd of a negative
		issue_instr(OP_OPR, 2'd0, OPR_NEG, '0);
		issue_instr(OP_OPR, 2'd0, 32'd14, '0);             // unknown sub-operation
		issue_instr(OP_CAL, 2'd0, 32'd100, '0);
		issue_instr(OP_INC, 2'd0, 32'd4, '0);
		issue_instr(OP_CAL, 2'd3, 32'hffff_ff00, '0);      // deep static link walk
		issue_instr(OP_INC, 2'd0, 32'd4, '0);
		issue_instr(OP_LOD, 2'd3, 32'd1, '0);
		issue_instr(OP_STO, 2'd2, 32'd0, '0);
		issue_instr(OP_OPR, 2'd0, OPR_RET, '0);
		issue_instr(OP_STO, 2'd0, 32'h8000_0000, '0);      // address out of range
		issue_instr(OP_INC, 2'd0, 32'h7fff_ffff, '0);
		issue_instr(OP_JPC, 2'd0, 32'd7, '0);
		issue_instr(OP_SIO, 2'd0, SIO_WRITE, '0);
		issue_instr(OP_SIO, 2'd1, 32'd9, '0);              // unknown I/O code
		issue_instr(OP_SIO, 2'd0, SIO_HALT, '0);
		issue_instr(4'd15, 2'd3, 32'hffff_ffff, 32'hffff_ffff);
		wait_idle();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 8; recv_stall_pct = 8; end
			endcase
			for (int i = 0; i < RANDOM_ITEMS / 4; i++) random_instr();
			wait_idle();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d instructions sent, %0d results checked, %0d faults, %0d writes",
			items_sent, results_seen, errors_seen, writes_seen);
		if (failures == 0 && result_expected.size() == 0)
			$display("pcode_stack_machine_exec_top_tb: PASS");
		else
			$display("pcode_stack_machine_exec_top_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
